// File: sv/bc45_pkg.sv
// Package for the BC4/BC5 block decoder: shared types, codes and constants.
// No dependencies; compile first.
`default_nettype none

package bc45_pkg;

    localparam int unsigned TEXELS = 16;

    // Palette selector codes with a fixed meaning
    localparam logic [2:0] SEL_E0   = 3'd0;
    localparam logic [2:0] SEL_E1   = 3'd1;
    localparam logic [2:0] SEL_ZERO = 3'd6;
    localparam logic [2:0] SEL_FULL = 3'd7;

    localparam logic [10:0] BIAS7 = 11'd3;
    localparam logic [10:0] BIAS5 = 11'd2;

    // Reciprocals scaled by 2**RECIP_SHIFT, exact for sums below 2048
    localparam int unsigned RECIP_SHIFT = 14;
    localparam logic [11:0] RECIP7 = 12'd2341;
    localparam logic [11:0] RECIP5 = 12'd3277;

    // Normal Z: 255**2 and the final offset
    localparam logic [16:0] Z_UNIT_SQ = 17'd65025;
    localparam logic [8:0]  Z_BIAS    = 9'd255;

    typedef enum logic [1:0] {
        DIV_NONE = 2'd0,
        DIV_7    = 2'd1,
        DIV_5    = 2'd2
    } t_div;

    typedef struct packed {
        logic [3:0] idx;
        logic       last;
        logic       bc5;
    } t_tag;

    typedef struct packed {
        logic [9:0] rem;
        logic [7:0] root;
    } t_sqrt;

endpackage

`default_nettype wire

// File: sv/bc45_blk_if.sv
// Input channel interface: one compressed block word per handshake.
// Standalone; no package needed.
`default_nettype none

interface bc45_blk_if;
    logic        valid;
    logic        ready;
    logic [63:0] red_block;
    logic [63:0] green_block;

    modport source (output valid, output red_block, output green_block, input ready);
    modport sink   (input valid, input red_block, input green_block, output ready);
endinterface

`default_nettype wire

// File: sv/bc45_texel_if.sv
// Output channel interface: one decoded texel word per handshake.
// Standalone; no package needed.
`default_nettype none

interface bc45_texel_if;
    logic       valid;
    logic       ready;
    logic [3:0] texel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;

    modport source (output valid, output texel_index, output red, output green,
                    output blue, output last, input ready);
    modport sink   (input valid, input texel_index, input red, input green,
                    input blue, input last, output ready);
endinterface

`default_nettype wire

// File: sv/bc4_bc5_block_decoder.sv
// BC4/BC5 block decoder top level: block serializer, two channel decoders,
// normal Z pipeline and output register. Uses bc45_pkg, both interfaces,
// bc45_chan and bc45_isqrt.
// Throughput: one texel word per cycle unless the output stalls; the serializer takes
// the next block as its sixteenth texel leaves, so blocks follow back to back.
// Reset (synchronous, active low): clears all valid bits and sets format to BC4.
`default_nettype none

module bc4_bc5_block_decoder import bc45_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fmt_we,
    input  logic          i_fmt_wdata,
    bc45_blk_if.sink      i_blk,
    bc45_texel_if.source  o_texel
);

    // Stage map:
    //   S0      serializer holding the block and the texel count
    //   S1..S2  channel decode (inside bc45_chan)
    //   S3      distance squares from the center of the byte range
    //   S4      clamped Z squared
    //   S5..S8  square root (inside bc45_isqrt)
    //   S9      output register
    // The whole pipe moves on one enable; valid bits ride along with the data.

    logic        r_fmt;
    logic        r_busy;
    logic [3:0]  r_cnt;
    logic [63:0] r_red_blk;
    logic [63:0] r_grn_blk;
    logic        r_bc5;

    logic        w_en;
    logic        w_accept;
    logic        w_s0_last;
    t_tag        n_tag;

    logic [8:1]  r_vld;
    t_tag        r_tag [1:8];

    logic [7:0]  w_red2;
    logic [7:0]  w_grn2;
    logic [7:0]  r_red [3:8];
    logic [7:0]  r_grn [3:8];

    logic [7:0]  w_abs_red;
    logic [7:0]  w_abs_grn;
    logic [15:0] r_sq_red;
    logic [15:0] r_sq_grn;
    logic [16:0] w_sq_sum;
    logic [15:0] n_rad;
    logic [15:0] r_rad;
    logic [7:0]  w_root;

    logic        r_out_vld;
    logic [3:0]  r_out_idx;
    logic [7:0]  r_out_red;
    logic [7:0]  r_out_grn;
    logic [7:0]  r_out_blu;
    logic        r_out_last;
    logic [7:0]  n_out_grn;
    logic [7:0]  n_out_blu;

    // Advance everything unless a word sits in the output register unclaimed
    assign w_en      = !r_out_vld || o_texel.ready;
    assign w_s0_last = (r_cnt == 4'(TEXELS - 1));

    // Take a new block when idle, or as the current block's last texel moves on
    assign i_blk.ready = !r_busy || (w_en && w_s0_last);
    assign w_accept    = i_blk.valid && i_blk.ready;

    // Format register: only bit 0 of the data exists
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= 1'b0;
        end else if (i_fmt_we) begin
            r_fmt <= i_fmt_wdata;
        end
    end

    // Serializer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (w_en && r_busy) begin
            if (w_s0_last) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 4'd1;
            end
        end
    end

    // Hold the block and its format for all sixteen texels
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_red_blk <= i_blk.red_block;
            r_grn_blk <= i_blk.green_block;
            r_bc5     <= r_fmt;
        end
    end

    assign n_tag.idx  = r_cnt;
    assign n_tag.last = w_s0_last;
    assign n_tag.bc5  = r_bc5;

    bc45_chan u_chan_red (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_blk (r_red_blk),
        .i_cnt (r_cnt),
        .o_val (w_red2)
    );

    // Decoded even in BC4 mode; masked at the output
    bc45_chan u_chan_grn (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_blk (r_grn_blk),
        .i_cnt (r_cnt),
        .o_val (w_grn2)
    );

    // |2v - 255| without a subtractor: odd values above the midpoint,
    // the complement of 2v below it
    assign w_abs_red = w_red2[7] ? {w_red2[6:0], 1'b1} : ~{w_red2[6:0], 1'b0};
    assign w_abs_grn = w_grn2[7] ? {w_grn2[6:0], 1'b1} : ~{w_grn2[6:0], 1'b0};

    // Clamp Z squared at zero when the vector is longer than unit length
    assign w_sq_sum = 17'(r_sq_red) + 17'(r_sq_grn);
    assign n_rad    = (w_sq_sum >= Z_UNIT_SQ) ? '0 : 16'(Z_UNIT_SQ - w_sq_sum);

    bc45_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r_rad),
        .o_root (w_root)
    );

    // Drop green and blue to zero in BC4 mode
    assign n_out_grn = r_tag[8].bc5 ? r_grn[8] : '0;
    assign n_out_blu = r_tag[8].bc5 ? 8'((9'(w_root) + Z_BIAS) >> 1) : '0;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_vld     <= {r_vld[7:1], r_busy};
            r_out_vld <= r_vld[8];
        end
    end

    // Payload stages
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tag[1] <= n_tag;
            for (int k = 2; k <= 8; k++) r_tag[k] <= r_tag[k-1];

            r_red[3] <= w_red2;
            r_grn[3] <= w_grn2;
            for (int k = 4; k <= 8; k++) begin
                r_red[k] <= r_red[k-1];
                r_grn[k] <= r_grn[k-1];
            end

            r_sq_red <= 16'(w_abs_red) * 16'(w_abs_red);
            r_sq_grn <= 16'(w_abs_grn) * 16'(w_abs_grn);
            r_rad    <= n_rad;

            r_out_idx  <= r_tag[8].idx;
            r_out_last <= r_tag[8].last;
            r_out_red  <= r_red[8];
            r_out_grn  <= n_out_grn;
            r_out_blu  <= n_out_blu;
        end
    end

    assign o_texel.valid       = r_out_vld;
    assign o_texel.texel_index = r_out_idx;
    assign o_texel.red         = r_out_red;
    assign o_texel.green       = r_out_grn;
    assign o_texel.blue        = r_out_blu;
    assign o_texel.last        = r_out_last;

endmodule

`default_nettype wire

// File: sv/bc45_chan.sv
// One channel of texel decode: palette entry select, weighted sum, then
// division by 7 or 5 through a scaled reciprocal. Two register stages; uses bc45_pkg.
`default_nettype none

module bc45_chan import bc45_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_blk,
    input  logic [3:0]  i_cnt,
    output logic [7:0]  o_val
);

    logic [7:0]  w_e0;
    logic [7:0]  w_e1;
    logic [5:0]  w_pos;
    logic [2:0]  w_sel;
    logic [2:0]  w_w0;
    logic [2:0]  w_w1;
    logic [10:0] n_sum;
    t_div        n_kind;
    logic [10:0] r_sum;
    t_div        r_kind;
    logic [22:0] w_prod;
    logic [7:0]  n_val;
    logic [7:0]  r_val;

    assign w_e0  = i_blk[7:0];
    assign w_e1  = i_blk[15:8];
    assign w_pos = 6'd16 + 6'(i_cnt) * 6'd3;
    assign w_sel = i_blk[w_pos +: 3];

    always_comb begin
        n_sum  = '0;
        n_kind = DIV_NONE;
        w_w0   = '0;
        w_w1   = '0;
        priority if (w_sel == SEL_E0) begin
            n_sum = 11'(w_e0);
        end else if (w_sel == SEL_E1) begin
            n_sum = 11'(w_e1);
        end else if (w_e0 > w_e1) begin
            w_w0   = 3'(4'd8 - 4'(w_sel));
            w_w1   = w_sel - 3'd1;
            n_kind = DIV_7;
            n_sum  = 11'(w_w0) * 11'(w_e0) + 11'(w_w1) * 11'(w_e1) + BIAS7;
        end else if (w_sel == SEL_ZERO) begin
            n_sum = '0;
        end else if (w_sel == SEL_FULL) begin
            n_sum = 11'(8'hFF);
        end else begin
            w_w0   = 3'(4'd6 - 4'(w_sel));
            w_w1   = w_sel - 3'd1;
            n_kind = DIV_5;
            n_sum  = 11'(w_w0) * 11'(w_e0) + 11'(w_w1) * 11'(w_e1) + BIAS5;
        end
    end

    always_comb begin
        w_prod = '0;
        n_val  = r_sum[7:0];
        unique case (r_kind)
            DIV_7: begin
                w_prod = 23'(r_sum) * 23'(RECIP7);
                n_val  = w_prod[RECIP_SHIFT +: 8];
            end
            DIV_5: begin
                w_prod = 23'(r_sum) * 23'(RECIP5);
                n_val  = w_prod[RECIP_SHIFT +: 8];
            end
            DIV_NONE: n_val = r_sum[7:0];
            default:  n_val = r_sum[7:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum  <= n_sum;
            r_kind <= n_kind;
            r_val  <= n_val;
        end
    end

    assign o_val = r_val;

endmodule

`default_nettype wire

// File: sv/bc45_isqrt.sv
// Pipelined integer square root of a 16-bit value, two result bits per stage,
// four register stages; uses bc45_pkg.
`default_nettype none

module bc45_isqrt import bc45_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [15:0] i_rad,
    output logic [7:0]  o_root
);

    t_sqrt       r_st  [0:3];
    t_sqrt       n_st  [0:3];
    logic [15:0] r_rad [0:2];
    logic [15:0] n_rad [0:2];

    // One restoring digit step: bring down two bits, try root*4+1
    function automatic t_sqrt sqrt_step(input t_sqrt s, input logic [1:0] pair);
        t_sqrt       o;
        logic [11:0] acc;
        logic [11:0] trial;
        acc   = {s.rem, pair};
        trial = {2'b00, s.root, 2'b01};
        if (acc >= trial) begin
            o.rem  = 10'(acc - trial);
            o.root = {s.root[6:0], 1'b1};
        end else begin
            o.rem  = acc[9:0];
            o.root = {s.root[6:0], 1'b0};
        end
        return o;
    endfunction

    always_comb begin
        n_st[0]  = sqrt_step(sqrt_step('0, i_rad[15:14]), i_rad[13:12]);
        n_rad[0] = {i_rad[11:0], 4'b0};
        for (int k = 1; k < 4; k++) begin
            n_st[k] = sqrt_step(sqrt_step(r_st[k-1], r_rad[k-1][15:14]),
                                r_rad[k-1][13:12]);
        end
        for (int k = 1; k < 3; k++) begin
            n_rad[k] = {r_rad[k-1][11:0], 4'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 4; k++) r_st[k] <= n_st[k];
            for (int k = 0; k < 3; k++) r_rad[k] <= n_rad[k];
        end
    end

    assign o_root = r_st[3].root;

endmodule

`default_nettype wire

// File: sv/bc45_chk.sv
// Port-level checker for the BC4/BC5 block decoder and its bind statement.
// Depends on bc4_bc5_block_decoder and its interface ports.
`default_nettype none

module bc45_chk (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_fmt_we,
    input wire       i_fmt_wdata,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire [3:0] i_idx,
    input wire [7:0] i_green,
    input wire [7:0] i_blue,
    input wire       i_last
);

    logic       r_fmt;
    logic [3:0] r_exp_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt     <= 1'b0;
            r_exp_idx <= '0;
        end else begin
            if (i_fmt_we) r_fmt <= i_fmt_wdata;
            if (i_out_valid && i_out_ready) r_exp_idx <= r_exp_idx + 4'd1;
        end
    end

    // Texels of each block leave in raster order, blocks back to back
    a_idx_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready |-> i_idx == r_exp_idx)
        else $error("texel index out of order");

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_last == (i_idx == 4'd15)))
        else $error("last flag not on the sixteenth texel");

    a_bc4_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !r_fmt |-> i_green == 8'd0 && i_blue == 8'd0)
        else $error("green or blue nonzero in BC4 mode");

    a_bc5_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_fmt |-> i_blue >= 8'd127)
        else $error("normal Z below midpoint in BC5 mode");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output word dropped while stalled");

endmodule

bind bc4_bc5_block_decoder bc45_chk u_bc45_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_fmt_we    (i_fmt_we),
    .i_fmt_wdata (i_fmt_wdata),
    .i_out_valid (o_texel.valid),
    .i_out_ready (o_texel.ready),
    .i_idx       (o_texel.texel_index),
    .i_green     (o_texel.green),
    .i_blue      (o_texel.blue),
    .i_last      (o_texel.last)
);

`default_nettype wire

// File: verif/bc4_bc5_block_decoder_checker.sv
`timescale 1ns / 1ps
// Checker for the BC4/BC5 block decoder. It watches the block and texel channels,
// predicts the sixteen texel words of every accepted block and compares them in order.
// Depends on bc45_pkg, bc45_blk_if and bc45_texel_if.

module bc4_bc5_block_decoder_checker import bc45_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_fmt_we,
    input  logic   i_fmt_wdata,
    bc45_blk_if    i_blk,
    bc45_texel_if  i_texel,
    output int     o_mismatches,
    output int     o_due,
    output int     o_texels_checked
);

    localparam int MAX_PRINTS = 50;

    typedef struct packed {
        logic [3:0] idx;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } texel_t;

    texel_t texel_due_q[$];
    texel_t want;
    logic   bc5_mode = 1'b0;
    int     mismatch_count = 0;
    int     checked_count = 0;
    int     due_count = 0;

    assign o_mismatches     = mismatch_count;
    assign o_due            = due_count;
    assign o_texels_checked = checked_count;

    // Palette lookup for one texel of one channel block
    function automatic logic [7:0] channel_value(logic [63:0] blk, int unsigned t);
        logic [2:0]  sel;
        int unsigned e0;
        int unsigned e1;
        int unsigned k;
        sel = blk[16 + 3 * t +: 3];
        e0  = blk[7:0];
        e1  = blk[15:8];
        k   = sel;
        k   = k - 1;
        if (sel == SEL_E0) return e0[7:0];
        if (sel == SEL_E1) return e1[7:0];
        if (e0 > e1) return 8'(((7 - k) * e0 + k * e1 + 3) / 7);
        if (sel == SEL_ZERO) return 8'd0;
        if (sel == SEL_FULL) return 8'd255;
        return 8'(((5 - k) * e0 + k * e1 + 2) / 5);
    endfunction

    function automatic int unsigned floor_root(int unsigned v);
        int unsigned root;
        int unsigned trial;
        root = 0;
        for (int unsigned b = 128; b != 0; b = b >> 1) begin
            trial = root + b;
            if (trial * trial <= v) root = trial;
        end
        return root;
    endfunction

    function automatic logic [7:0] normal_z(logic [7:0] r, logic [7:0] g);
        int dr;
        int dg;
        int s;
        dr = 2 * int'(r) - 255;
        dg = 2 * int'(g) - 255;
        s  = 65025 - dr * dr - dg * dg;
        if (s < 0) s = 0;
        return 8'((255 + floor_root(s)) >> 1);
    endfunction

    function automatic texel_t decode_texel(logic [63:0] rblk, logic [63:0] gblk,
                                            logic bc5, int unsigned t);
        texel_t tx;
        tx.idx   = 4'(t);
        tx.red   = channel_value(rblk, t);
        tx.green = 8'd0;
        tx.blue  = 8'd0;
        tx.last  = (t == TEXELS - 1);
        if (bc5) begin
            tx.green = channel_value(gblk, t);
            tx.blue  = normal_z(tx.red, tx.green);
        end
        return tx;
    endfunction

    task automatic report_mismatch(string what, int unsigned exp_val, int unsigned got_val);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("[%0t] mismatch on %s: expected %0d, got %0d (texel word %0d)",
                     $time, what, exp_val, got_val, checked_count);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            bc5_mode = 1'b0;
        end else begin
            if (i_texel.valid && i_texel.ready) begin
                if (texel_due_q.size() == 0) begin
                    report_mismatch("unexpected texel word, index", 0, i_texel.texel_index);
                end else begin
                    want = texel_due_q.pop_front();
                    checked_count++;
                    if (i_texel.texel_index !== want.idx)
                        report_mismatch("texel_index", want.idx, i_texel.texel_index);
                    if (i_texel.red !== want.red)
                        report_mismatch("red", want.red, i_texel.red);
                    if (i_texel.green !== want.green)
                        report_mismatch("green", want.green, i_texel.green);
                    if (i_texel.blue !== want.blue)
                        report_mismatch("blue", want.blue, i_texel.blue);
                    if (i_texel.last !== want.last)
                        report_mismatch("last", want.last, i_texel.last);
                end
            end
            if (i_blk.valid && i_blk.ready) begin
                for (int unsigned t = 0; t < TEXELS; t++)
                    texel_due_q.push_back(decode_texel(i_blk.red_block, i_blk.green_block,
                                                       bc5_mode, t));
            end
            if (i_fmt_we) bc5_mode = i_fmt_wdata;
        end
        due_count <= texel_due_q.size();
    end

endmodule

// File: verif/bc4_bc5_block_decoder_test.sv
`timescale 1ns / 1ps
// Testbench top for the BC4/BC5 block decoder: clock, reset, block stimulus, texel
// back-pressure and the verdict. Depends on bc45_pkg, both channel interfaces, the
// decoder itself and bc4_bc5_block_decoder_checker.

module bc4_bc5_block_decoder_test;
    import bc45_pkg::*;

    localparam logic FMT_BC4 = 1'b0;
    localparam logic FMT_BC5 = 1'b1;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 8;
    localparam int IDLE_PCT       = 26;
    localparam int SETTLE_CYCLES  = 16;
    localparam int SQUEEZE_CYCLES = 300;
    localparam int CYCLE_LIMIT    = 200000;

    logic i_clk;
    logic i_rst_n;
    logic i_fmt_we;
    logic i_fmt_wdata;

    bc45_blk_if   blk_ch();
    bc45_texel_if texel_ch();

    int mismatches;
    int due;
    int texels_checked;

    int tx_idle_pct = IDLE_PCT;
    int rx_idle_pct = IDLE_PCT;
    bit squeeze_req = 1'b0;
    logic fmt_now   = FMT_BC4;
    int bc4_blocks  = 0;
    int bc5_blocks  = 0;
    int cycle_count = 0;

    bc4_bc5_block_decoder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fmt_we    (i_fmt_we),
        .i_fmt_wdata (i_fmt_wdata),
        .i_blk       (blk_ch),
        .o_texel     (texel_ch)
    );

    bc4_bc5_block_decoder_checker checker_inst (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fmt_we         (i_fmt_we),
        .i_fmt_wdata      (i_fmt_wdata),
        .i_blk            (blk_ch),
        .i_texel          (texel_ch),
        .o_mismatches     (mismatches),
        .o_due            (due),
        .o_texels_checked (texels_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Watchdog: give up if the run hangs
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk) cycle_count++;
        $display("timeout after %0d cycles with %0d texel words still due", cycle_count, due);
        $display("TEST FAILED");
        $finish;
    end

    // Texel sink: random stalls, plus one long hold-off on request so the decoder
    // backs up all the way to its block input.
    initial begin
        texel_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (squeeze_req) begin
                squeeze_req = 1'b0;
                texel_ch.ready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge i_clk);
            end
            texel_ch.ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Pack endpoints and sixteen 3-bit selectors into one channel block
    function automatic logic [63:0] make_block(logic [7:0] e0, logic [7:0] e1,
                                               logic [47:0] sels);
        return {sels, e1, e0};
    endfunction

    // Selectors walking through all eight palette entries, starting anywhere
    function automatic logic [47:0] ramp_sels(logic [2:0] start);
        logic [47:0] s;
        for (int t = 0; t < 16; t++) s[3 * t +: 3] = start + 3'(t);
        return s;
    endfunction

    // Random channel block, biased toward equal and extreme endpoints
    function automatic logic [63:0] random_channel();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(7))
            0, 1: w[15:8] = w[7:0];
            2: begin
                w[7:0]  = 8'hFF;
                w[15:8] = 8'h00;
            end
            3: begin
                w[7:0]  = 8'h00;
                w[15:8] = 8'hFF;
            end
            default: ;
        endcase
        return w;
    endfunction

    // Offer one block word; leave valid high on return so back-to-back words
    // need no second assignment in the same step.
    task automatic send_block(logic [63:0] r, logic [63:0] g);
        while ($urandom_range(99) < tx_idle_pct) begin
            blk_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        blk_ch.valid       <= 1'b1;
        blk_ch.red_block   <= r;
        blk_ch.green_block <= g;
        do @(posedge i_clk); while (!blk_ch.ready);
        if (fmt_now == FMT_BC5) bc5_blocks++;
        else bc4_blocks++;
    endtask

    // Drop valid and wait until every predicted texel word has come back
    task automatic drain();
        blk_ch.valid <= 1'b0;
        do @(posedge i_clk); while (due != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_format(logic fmt);
        i_fmt_we    <= 1'b1;
        i_fmt_wdata <= fmt;
        fmt_now = fmt;
        @(posedge i_clk);
        i_fmt_we    <= 1'b0;
    endtask

    task automatic random_phase(int count, int idle_pct);
        tx_idle_pct = idle_pct;
        rx_idle_pct = idle_pct;
        for (int n = 0; n < count; n++) send_block(random_channel(), random_channel());
    endtask

    initial begin
        // Hold every input at a known value through reset
        i_rst_n            <= 1'b0;
        i_fmt_we           <= 1'b0;
        i_fmt_wdata        <= 1'b0;
        blk_ch.valid       <= 1'b0;
        blk_ch.red_block   <= '0;
        blk_ch.green_block <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // BC4 straight out of reset: both palette kinds, equal endpoints, extremes.
        // The green block carries junk that must not leak into the texels.
        send_block(make_block(8'd255, 8'd0, ramp_sels(3'd0)), {$urandom, $urandom});
        send_block(make_block(8'd0, 8'd255, ramp_sels(3'd0)), {$urandom, $urandom});
        send_block(make_block(8'd128, 8'd128, ramp_sels(3'd3)), '1);
        send_block(make_block(8'd0, 8'd0, ramp_sels(3'd5)), '0);
        send_block(make_block(8'd255, 8'd255, ramp_sels(3'd1)), '1);
        send_block('1, '0);
        send_block('0, '1);
        send_block(make_block(8'd101, 8'd100, ramp_sels(3'd2)), {$urandom, $urandom});
        drain();

        // BC5: clamped normal Z, flat Z, mixed palettes, all-ones words
        write_format(FMT_BC5);
        send_block(make_block(8'd0, 8'd0, '0), make_block(8'd0, 8'd0, '0));
        send_block(make_block(8'd128, 8'd128, '0), make_block(8'd128, 8'd128, '0));
        send_block(make_block(8'd255, 8'd0, ramp_sels(3'd0)),
                   make_block(8'd0, 8'd255, ramp_sels(3'd4)));
        send_block(make_block(8'd17, 8'd200, ramp_sels(3'd7)),
                   make_block(8'd200, 8'd17, ramp_sels(3'd1)));
        send_block('1, '1);
        send_block('1, '0);
        send_block(random_channel(), random_channel());
        send_block(random_channel(), random_channel());
        drain();

        // Random BC4 with stalls on both sides
        write_format(FMT_BC4);
        random_phase(70, IDLE_PCT);
        drain();

        // Random BC5; hold the sink off for a long stretch while blocks keep coming
        write_format(FMT_BC5);
        squeeze_req = 1'b1;
        random_phase(70, IDLE_PCT);
        drain();

        // Run flat out with no idling at all
        write_format(FMT_BC5);
        random_phase(60, 0);
        drain();

        // Back to BC4 to check the mode switch undoes BC5 cleanly
        write_format(FMT_BC4);
        random_phase(64, IDLE_PCT);
        drain();

        $display("Decoded %0d BC4 and %0d BC5 blocks, %0d texel words compared.",
                 bc4_blocks, bc5_blocks, texels_checked);
        $display("Covered both palette kinds, equal and extreme endpoints, clamped Z, %0s",
                 "random stalls, a long sink hold-off and a no-idle stretch.");
        if (mismatches == 0 && due == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d texel words never arrived", mismatches, due);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
sv/bc45_pkg.sv
sv/bc45_blk_if.sv
sv/bc45_texel_if.sv
sv/bc45_chan.sv
sv/bc45_isqrt.sv
sv/bc4_bc5_block_decoder.sv
sv/bc45_chk.sv
verif/bc4_bc5_block_decoder_checker.sv
verif/bc4_bc5_block_decoder_test.sv
